@@ src/fss_pkg.sv @@
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and character helpers for the fuzzy subsequence
// scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int CHAR_W  = 8;
    localparam int SCORE_W = 10;
    localparam int LEN_W   = 5;
    localparam int GAP_W   = 3;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [LEN_W-1:0]  LEN_CAP    = 5'd24;
    localparam logic [GAP_W-1:0]  GAP_CAP    = 3'd4;

    localparam logic signed [5:0] ADD_BASE     = 6'sd1;
    localparam logic signed [5:0] ADD_CONSEC   = 6'sd6;
    localparam logic signed [5:0] ADD_START    = 6'sd12;
    localparam logic signed [5:0] ADD_BOUNDARY = 6'sd8;

    localparam logic signed [SCORE_W-1:0] SCORE_NONE = -10'sd1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      matched;
    } result_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    // (24 - len) / 3 for len in 0..24
    function automatic logic [3:0] length_bonus(input logic [LEN_W-1:0] len);
        logic [3:0] b;
        case (len) inside
            [5'd0:5'd0]:   b = 4'd8;
            [5'd1:5'd3]:   b = 4'd7;
            [5'd4:5'd6]:   b = 4'd6;
            [5'd7:5'd9]:   b = 4'd5;
            [5'd10:5'd12]: b = 4'd4;
            [5'd13:5'd15]: b = 4'd3;
            [5'd16:5'd18]: b = 4'd2;
            [5'd19:5'd21]: b = 4'd1;
            default:       b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

@@ src/fss_query.sv @@
// ----------------------------------------------------------------------------
// fss_query
// Query configuration registers, with folded characters and the mask of
// non-space positions inside the active length.
// ----------------------------------------------------------------------------
module fss_query #(
    parameter int MAX_QUERY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fss_pkg::CFG_W-1:0]           cfg_data,
    output logic [MAX_QUERY-1:0][fss_pkg::CHAR_W-1:0] q_chars,
    output logic [MAX_QUERY-1:0]                q_mask,
    output logic                                q_empty
);
    localparam int PosW = $clog2(MAX_QUERY + 1);

    logic [fss_pkg::CFG_W-1:0] low_reg;
    logic [fss_pkg::CFG_W-1:0] high_reg;
    logic [fss_pkg::LEN_W-1:0] len_reg;
    logic [PosW-1:0]           qlen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fss_pkg::CFG_QUERY_LOW:  low_reg  <= cfg_data;
                fss_pkg::CFG_QUERY_HIGH: high_reg <= cfg_data;
                fss_pkg::CFG_QUERY_LEN:  len_reg  <= cfg_data[fss_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp an oversized length to the query capacity
    assign qlen = (len_reg > fss_pkg::LEN_W'(MAX_QUERY)) ? PosW'(MAX_QUERY)
                                                           : PosW'(len_reg);
    assign q_empty = (qlen == '0);

    for (genvar i = 0; i < MAX_QUERY; i++)
    begin : g_char
        logic [fss_pkg::CHAR_W-1:0] raw;
        if (i < 8)
        begin : g_low
            assign raw = low_reg[i*8 +: 8];
        end
        else
        begin : g_high
            assign raw = high_reg[(i-8)*8 +: 8];
        end
        assign q_chars[i] = fss_pkg::fold(raw);
        assign q_mask[i]  = (q_chars[i] != fss_pkg::CHAR_SPACE) && (PosW'(i) < qlen);
    end

endmodule

@@ src/fss_step.sv @@
// ----------------------------------------------------------------------------
// fss_step
// Per-character match and score update; holds the running string state and
// forms the result on the final item.
// ----------------------------------------------------------------------------
module fss_step #(
    parameter int MAX_QUERY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [fss_pkg::CHAR_W-1:0]          text_char,
    input  logic                                no_char,
    input  logic                                last_char,
    input  logic [MAX_QUERY-1:0][fss_pkg::CHAR_W-1:0] q_chars,
    input  logic [MAX_QUERY-1:0]                q_mask,
    input  logic                                q_empty,
    output logic                                res_valid,
    output fss_pkg::result_t                    res
);
    localparam int PosW = $clog2(MAX_QUERY + 1);

    logic [PosW-1:0]                  pos_reg, pos_next;
    logic signed [fss_pkg::SCORE_W-1:0] sum_reg, sum_next;
    logic [fss_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [fss_pkg::GAP_W-1:0]        gap_reg, gap_next;
    logic                             pm_reg, pm_next;
    logic                             pa_reg, pa_next;

    logic                             found;
    logic [PosW-1:0]                  p;
    logic [fss_pkg::CHAR_W-1:0]       qc;
    logic                             hit;
    logic signed [5:0]                add;
    logic                             done;
    logic signed [fss_pkg::SCORE_W-1:0] final_score;

    // first non-space query position at or after the current one
    always_comb
    begin
        found = 1'b0;
        p     = '0;
        qc    = '0;
        for (int i = MAX_QUERY - 1; i >= 0; i--)
        begin
            if (q_mask[i] && (PosW'(i) >= pos_reg))
            begin
                found = 1'b1;
                p     = PosW'(i);
                qc    = q_chars[i];
            end
        end
        if (!found)
        begin
            p = PosW'(MAX_QUERY);
            for (int i = 0; i < MAX_QUERY; i++)
            begin
                if (q_mask[i] || (i == 0))
                begin
                    p = (q_mask[i] || i == 0) ? p : p;
                end
            end
        end
    end

    assign hit = found && (fss_pkg::fold(text_char) == qc);

    always_comb
    begin
        add = fss_pkg::ADD_BASE - $signed({3'b000, gap_reg});
        if (pm_reg)
        begin
            add = add + fss_pkg::ADD_CONSEC;
        end
        if (len_reg == '0)
        begin
            add = add + fss_pkg::ADD_START;
        end
        else if (!pa_reg)
        begin
            add = add + fss_pkg::ADD_BOUNDARY;
        end
    end

    always_comb
    begin
        if (hit)
        begin
            pos_next = PosW'(p + 1'b1);
            sum_next = sum_reg + fss_pkg::SCORE_W'(add);
            gap_next = 3'd1;
        end
        else
        begin
            // past the end, pos only needs to sit beyond every mask bit
            pos_next = found ? p : pos_reg;
            sum_next = sum_reg;
            gap_next = (gap_reg < fss_pkg::GAP_CAP) ? gap_reg + 3'd1 : gap_reg;
        end
        pm_next  = hit;
        pa_next  = fss_pkg::is_alnum(text_char);
        len_next = (len_reg < fss_pkg::LEN_CAP) ? len_reg + 5'd1 : len_reg;
    end

    // all non-space query characters consumed
    always_comb
    begin
        done = 1'b1;
        for (int i = 0; i < MAX_QUERY; i++)
        begin
            if (q_mask[i] && (PosW'(i) >= pos_next))
            begin
                done = 1'b0;
            end
        end
    end

    assign final_score = sum_next +
                         fss_pkg::SCORE_W'(fss_pkg::length_bonus(len_next));

    assign res_valid = accept && (no_char || last_char);

    always_comb
    begin
        if (q_empty)
        begin
            res.score   = '0;
            res.matched = 1'b1;
        end
        else if (!no_char && done)
        begin
            res.score   = final_score;
            res.matched = 1'b1;
        end
        else
        begin
            res.score   = fss_pkg::SCORE_NONE;
            res.matched = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
            len_reg <= '0;
            gap_reg <= '0;
            pm_reg  <= 1'b0;
            pa_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (no_char || last_char)
            begin
                pos_reg <= '0;
                sum_reg <= '0;
                len_reg <= '0;
                gap_reg <= '0;
                pm_reg  <= 1'b0;
                pa_reg  <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
                len_reg <= len_next;
                gap_reg <= gap_next;
                pm_reg  <= pm_next;
                pa_reg  <= pa_next;
            end
        end
    end

endmodule

@@ src/fuzzy_subsequence_scorer_unit.sv @@
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit
// Streaming fuzzy subsequence scorer for one configured query.
// ----------------------------------------------------------------------------
// The block takes a candidate string one character per transaction and scores
// it against the configured query (up to MAX_QUERY characters, ASCII
// case-folded, spaces in the query skipped) as a greedy subsequence match. It
// takes one character every clock cycle while s_axis_tready is high: the
// match, the score update and the length count all complete in the cycle the
// transaction is accepted, and the running string state is written back at
// that edge. On the transaction that ends the string (tlast, or tuser set for
// an empty string) the score is loaded into the output register and appears
// on the master side in the next cycle. The slave side keeps accepting while
// that result is held, unless a stalled result still occupies the output
// register. Write the query registers only while no string is in flight.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit #(
    parameter int MAX_QUERY = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_W-1:0]     cfg_data,
    // slave side: one text character per transaction
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] text_char
    input  logic                          s_axis_tuser,  // [0] no_char
    input  logic                          s_axis_tlast,  // last_char
    // master side: one score per finished string
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [9:0] score, [15:10] zero
    output logic                          m_axis_tuser   // [0] matched
);

    logic [MAX_QUERY-1:0][fss_pkg::CHAR_W-1:0] q_chars;
    logic [MAX_QUERY-1:0]                      q_mask;
    logic                                      q_empty;

    logic             accept;
    logic             res_valid;
    fss_pkg::result_t res;

    logic             out_valid_reg;
    fss_pkg::result_t out_reg;

    // Query registers and their decoded form.
    fss_query #(
        .MAX_QUERY (MAX_QUERY)
    ) u_query (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_chars   (q_chars),
        .q_mask    (q_mask),
        .q_empty   (q_empty)
    );

    // Accept whenever the output register is free or draining this cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    fss_step #(
        .MAX_QUERY (MAX_QUERY)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_char (s_axis_tdata),
        .no_char   (s_axis_tuser),
        .last_char (s_axis_tlast),
        .q_chars   (q_chars),
        .q_mask    (q_mask),
        .q_empty   (q_empty),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: load a finished score, drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_reg.score};
    assign m_axis_tuser  = out_reg.matched;

endmodule
